@@ design/ramr_pkg.sv @@
// Shared types and constants for the rational add/multiply/reduce block.
package ramr_pkg;

    localparam int FIELD_WIDTH_DEF = 16;
    localparam int WORD_W          = 64;
    localparam int RES_NUM_W       = 33;
    localparam int RES_DEN_W       = 32;
    localparam int SHIFT_W         = 6;
    localparam int DIV_CNT_W       = 7;
    localparam int DIV_STEPS       = WORD_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_CHECK,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        MP_AN_BN,
        MP_AN_BD,
        MP_AD_BN,
        MP_AD_BD
    } mul_pair_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD_NUM,
        ACC_ADD_NUM,
        ACC_LOAD_DEN
    } acc_op_t;

    typedef enum logic {
        DS_NUM,
        DS_DEN
    } div_src_t;

    typedef struct packed {
        logic      load;
        logic      mul_en;
        mul_pair_t mul_pair;
        acc_op_t   acc;
        logic      den_one;
        logic      gcd_init;
        logic      gcd_step;
        logic      div_start;
        div_src_t  div_src;
        logic      div_step;
        logic      take_num;
        logic      take_den;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_mul;
        logic den_pos;
        logic num_zero;
        logic gcd_done;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

@@ design/ramr_ctrl.sv @@
// Sequencing state machine for the rational add/multiply/reduce block.
module ramr_ctrl
    import ramr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_MUL0;
                end
            end
            S_MUL0:  state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_MUL3;
            S_MUL3:  state_next = S_CHECK;
            S_CHECK: begin
                if (status.den_pos && !status.num_zero) begin
                    state_next = S_GCD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_GCD: begin
                if (status.gcd_done) begin
                    state_next = S_DIVN;
                end
            end
            S_DIVN: begin
                if (status.div_done) begin
                    state_next = S_DIVD;
                end
            end
            S_DIVD: begin
                if (status.div_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = aresetn;
                cmd.load = s_tvalid && aresetn;
            end
            S_MUL0: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_pair = status.is_mul ? MP_AN_BN : MP_AN_BD;
            end
            S_MUL1: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_pair = MP_AD_BN;
                cmd.acc      = ACC_LOAD_NUM;
            end
            S_MUL2: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_pair = MP_AD_BD;
                cmd.acc      = status.is_mul ? ACC_NONE : ACC_ADD_NUM;
            end
            S_MUL3: begin
                cmd.acc = ACC_LOAD_DEN;
            end
            S_CHECK: begin
                if (status.den_pos) begin
                    cmd.den_one  = status.num_zero;
                    cmd.gcd_init = !status.num_zero;
                end
            end
            S_GCD: begin
                if (status.gcd_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DS_NUM;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIVN: begin
                if (status.div_done) begin
                    cmd.take_num  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DS_DEN;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_DIVD: begin
                if (status.div_done) begin
                    cmd.take_den = 1'b1;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_DONE: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ design/ramr_dp.sv @@
// Datapath: shared multiplier, binary GCD unit, restoring divider and output register.
module ramr_dp
    import ramr_pkg::*;
#(
    parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dp_cmd_t                       cmd,
    output dp_status_t                    status,
    input  logic                          action,
    input  logic signed [FIELD_WIDTH-1:0] a_num,
    input  logic signed [FIELD_WIDTH-1:0] a_den,
    input  logic signed [FIELD_WIDTH-1:0] b_num,
    input  logic signed [FIELD_WIDTH-1:0] b_den,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic        [RES_NUM_W-1:0]   res_num,
    output logic        [RES_DEN_W-1:0]   res_den
);

    localparam int PROD_W = 2 * FIELD_WIDTH;

    logic                          is_mul_reg;
    logic signed [FIELD_WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [FIELD_WIDTH-1:0] op_a, op_b;
    logic signed [PROD_W-1:0]      prod_reg;
    logic        [WORD_W-1:0]      prod_ext;

    logic [WORD_W-1:0]    num_reg, num_next;
    logic [WORD_W-1:0]    den_reg, den_next;
    logic                 neg_reg;
    logic [WORD_W-1:0]    mag_reg;
    logic [WORD_W-1:0]    mag;

    logic [WORD_W-1:0]    u_reg, u_next;
    logic [WORD_W-1:0]    v_reg, v_next;
    logic [SHIFT_W-1:0]   k_reg, k_next;
    logic                 u_gt_v;
    logic [WORD_W-1:0]    gcd_diff;

    logic [WORD_W-1:0]    g_reg;
    logic [WORD_W-1:0]    quo_reg, quo_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]    trial;

    logic                 m_valid_reg, m_valid_next;
    logic [RES_NUM_W-1:0] out_num_reg;
    logic [RES_DEN_W-1:0] out_den_reg;

    always_comb begin
        case (cmd.mul_pair)
            MP_AN_BN: begin
                op_a = an_reg;
                op_b = bn_reg;
            end
            MP_AN_BD: begin
                op_a = an_reg;
                op_b = bd_reg;
            end
            MP_AD_BN: begin
                op_a = ad_reg;
                op_b = bn_reg;
            end
            MP_AD_BD: begin
                op_a = ad_reg;
                op_b = bd_reg;
            end
            default: begin
                op_a = an_reg;
                op_b = bn_reg;
            end
        endcase
    end

    assign prod_ext = WORD_W'(prod_reg);
    assign mag      = num_reg[WORD_W-1] ? (~num_reg + 1'b1) : num_reg;

    always_comb begin
        num_next = num_reg;
        den_next = den_reg;
        case (cmd.acc)
            ACC_LOAD_NUM: num_next = prod_ext;
            ACC_ADD_NUM:  num_next = num_reg + prod_ext;
            ACC_LOAD_DEN: den_next = prod_ext;
            default:      num_next = num_reg;
        endcase
        if (cmd.den_one) begin
            den_next = WORD_W'(1);
        end
        if (cmd.take_num) begin
            num_next = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
        end
        if (cmd.take_den) begin
            den_next = quo_reg;
        end
    end

    assign u_gt_v   = u_reg > v_reg;
    assign gcd_diff = u_gt_v ? (u_reg - v_reg) : (v_reg - u_reg);

    always_comb begin
        u_next = u_reg;
        v_next = v_reg;
        k_next = k_reg;
        if (cmd.gcd_init) begin
            u_next = mag;
            v_next = den_reg;
            k_next = '0;
        end else if (cmd.gcd_step) begin
            if (!u_reg[0] && !v_reg[0]) begin
                u_next = u_reg >> 1;
                v_next = v_reg >> 1;
                k_next = k_reg + 1'b1;
            end else if (!u_reg[0]) begin
                u_next = u_reg >> 1;
            end else if (!v_reg[0]) begin
                v_next = v_reg >> 1;
            end else if (u_gt_v) begin
                u_next = gcd_diff >> 1;
            end else if (u_reg != v_reg) begin
                v_next = gcd_diff >> 1;
            end
        end
    end

    assign trial = {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (cmd.div_start) begin
            quo_next = (cmd.div_src == DS_NUM) ? mag_reg : den_reg;
            rem_next = '0;
            cnt_next = '0;
        end else if (cmd.div_step) begin
            cnt_next = cnt_reg + 1'b1;
            if (trial >= g_reg) begin
                rem_next = trial - g_reg;
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign m_valid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            is_mul_reg <= action;
            an_reg     <= a_num;
            ad_reg     <= a_den;
            bn_reg     <= b_num;
            bd_reg     <= b_den;
        end
        if (cmd.mul_en) begin
            prod_reg <= op_a * op_b;
        end
        if (cmd.gcd_init) begin
            neg_reg <= num_reg[WORD_W-1];
            mag_reg <= mag;
        end
        if (cmd.div_start && cmd.div_src == DS_NUM) begin
            g_reg <= u_reg << k_reg;
        end
        if (cmd.out_load) begin
            out_num_reg <= num_reg[RES_NUM_W-1:0];
            out_den_reg <= den_reg[RES_DEN_W-1:0];
        end
        num_reg <= num_next;
        den_reg <= den_next;
        u_reg   <= u_next;
        v_reg   <= v_next;
        k_reg   <= k_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign status.is_mul   = is_mul_reg;
    assign status.den_pos  = !den_reg[WORD_W-1] && (den_reg != '0);
    assign status.num_zero = (num_reg == '0);
    assign status.gcd_done = u_reg[0] && v_reg[0] && (u_reg == v_reg);
    assign status.div_done = (cnt_reg == DIV_CNT_W'(DIV_STEPS));
    assign status.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign res_num  = out_num_reg;
    assign res_den  = out_den_reg;

endmodule

@@ design/rational_add_multiply_reduce.sv @@
// Top level of the rational add/multiply/reduce block.
//
// Input word: an action bit (add or multiply) and two signed fractions.
// Result word: the signed numerator and denominator of the sum or product,
// reduced by the greatest common divisor when the denominator is positive;
// a zero numerator then gives 0/1. A zero or negative denominator passes
// the raw numerator and denominator through unreduced.
// One word is processed at a time. After acceptance, states S_MUL0 to
// S_MUL3 form the products on one shared multiplier, S_CHECK classifies
// the result, the binary GCD loop does one shift or subtract per step,
// and two 64-step restoring divisions on one shared divider produce the
// quotients. An unreduced result skips the GCD loop and the divisions.
// s_tready is high only while the block is idle. The result waits in an
// output register; a stalled receiver holds the finished word there, and
// the block holds its next result until it drains. Reset empties the
// output register and returns the block to idle.
module rational_add_multiply_reduce
    import ramr_pkg::*;
#(
    parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // action, a_num, a_den, b_num, b_den
    input  logic [((1 + 4 * FIELD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // res_num, res_den
    output logic [((RES_NUM_W + RES_DEN_W + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int M_USED_W = RES_NUM_W + RES_DEN_W;
    localparam int M_DATA_W = ((M_USED_W + 7) / 8) * 8;

    dp_cmd_t                       cmd;
    dp_status_t                    status;
    logic signed [FIELD_WIDTH-1:0] a_num, a_den, b_num, b_den;
    logic        [RES_NUM_W-1:0]   res_num;
    logic        [RES_DEN_W-1:0]   res_den;

    assign a_num = s_tdata[1 +: FIELD_WIDTH];
    assign a_den = s_tdata[1 + FIELD_WIDTH +: FIELD_WIDTH];
    assign b_num = s_tdata[1 + 2 * FIELD_WIDTH +: FIELD_WIDTH];
    assign b_den = s_tdata[1 + 3 * FIELD_WIDTH +: FIELD_WIDTH];

    assign m_tdata = M_DATA_W'({res_den, res_num});

    ramr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ramr_dp #(
        .FIELD_WIDTH (FIELD_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .action   (s_tdata[0]),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_num  (res_num),
        .res_den  (res_den)
    );

endmodule
